>>> rtl/sparc_v8_instruction_decoder_core_macros.svh
// Assertion macros for the SPARC v8 decoder core.
// Expects clk and rst_n in the scope of use; empty when SYNTH is defined.
`ifndef SPARC_V8_INSTRUCTION_DECODER_CORE_MACROS_SVH
`define SPARC_V8_INSTRUCTION_DECODER_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define SV8D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");
// next-cycle implication
`define SV8D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");
`else
`define SV8D_ASSERT_NOW(lbl, ante, cons)
`define SV8D_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/sv8d_pkg.sv
// Shared types, opcode constants and mnemonic tables of the SPARC v8 decoder.
// No dependencies.
package sv8d_pkg;

    // op field
    localparam logic [1:0] OP_FMT2  = 2'd0;
    localparam logic [1:0] OP_CALL  = 2'd1;
    localparam logic [1:0] OP_ARITH = 2'd2;
    localparam logic [1:0] OP_MEM   = 2'd3;

    // op2 field of format 2
    localparam logic [2:0] OP2_UNIMP = 3'd0;
    localparam logic [2:0] OP2_BICC  = 3'd2;
    localparam logic [2:0] OP2_SETHI = 3'd4;
    localparam logic [2:0] OP2_FBFCC = 3'd6;
    localparam logic [2:0] OP2_CBCCC = 3'd7;

    // op3 codes of format 3 arithmetic
    localparam logic [5:0] OP3_RDY   = 6'h28;
    localparam logic [5:0] OP3_RDTBR = 6'h2B;
    localparam logic [5:0] OP3_WRY   = 6'h30;
    localparam logic [5:0] OP3_WRTBR = 6'h33;
    localparam logic [5:0] OP3_FPOP1 = 6'h34;
    localparam logic [5:0] OP3_FPOP2 = 6'h35;
    localparam logic [5:0] OP3_RETT  = 6'h39;
    localparam logic [5:0] OP3_FLUSH = 6'h3B;

    // mnemonic numbers
    localparam logic [7:0] K_NONE   = 8'd0;
    localparam logic [7:0] K_CALL   = 8'd1;
    localparam logic [7:0] K_NOP    = 8'd2;
    localparam logic [7:0] K_SETHI  = 8'd3;
    localparam logic [7:0] K_UNIMP  = 8'd4;
    localparam logic [7:0] K_BICC   = 8'd5;
    localparam logic [7:0] K_FBFCC  = 8'd21;
    localparam logic [7:0] K_CBCCC  = 8'd37;
    localparam logic [7:0] K_LDFSR  = 8'd71;
    localparam logic [7:0] K_LDCSR  = 8'd74;
    localparam logic [7:0] K_STFSR  = 8'd85;
    localparam logic [7:0] K_STDFQ  = 8'd86;
    localparam logic [7:0] K_STCSR  = 8'd89;
    localparam logic [7:0] K_STDCQ  = 8'd90;
    localparam logic [7:0] K_RD     = 8'd130;
    localparam logic [7:0] K_WR     = 8'd131;
    localparam logic [7:0] K_FDIVD  = 8'd139;
    localparam logic [7:0] K_RETT   = 8'd155;
    localparam logic [7:0] K_FLUSH  = 8'd156;

    // special registers
    localparam logic [3:0] SR_NONE = 4'd0;
    localparam logic [3:0] SR_Y    = 4'd1;
    localparam logic [3:0] SR_ASR  = 4'd2;
    localparam logic [3:0] SR_FSR  = 4'd6;
    localparam logic [3:0] SR_FQ   = 4'd7;
    localparam logic [3:0] SR_CSR  = 4'd8;
    localparam logic [3:0] SR_CQ   = 4'd9;

    // register file class
    localparam logic [1:0] CLS_INT = 2'd0;
    localparam logic [1:0] CLS_FP  = 2'd1;
    localparam logic [1:0] CLS_CP  = 2'd2;

    // position of each cond value in the branch mnemonic lists
    localparam logic [7:0] BICC_POS [16] = '{
        8'd1, 8'd3, 8'd5, 8'd7, 8'd9, 8'd11, 8'd13, 8'd15,
        8'd0, 8'd2, 8'd4, 8'd6, 8'd8, 8'd10, 8'd12, 8'd14
    };
    localparam logic [7:0] FCC_POS [16] = '{
        8'd1, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2,
        8'd0, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15
    };

    // loads and stores, indexed by op3
    localparam logic [7:0] MEM_CODE [64] = '{
        8'd57, 8'd55, 8'd56, 8'd58, 8'd77, 8'd75, 8'd76, 8'd78,
        8'd0,  8'd53, 8'd54, 8'd0,  8'd0,  8'd65, 8'd0,  8'd67,
        8'd63, 8'd61, 8'd62, 8'd64, 8'd81, 8'd79, 8'd80, 8'd82,
        8'd0,  8'd59, 8'd60, 8'd0,  8'd0,  8'd66, 8'd0,  8'd68,
        8'd69, 8'd71, 8'd0,  8'd70, 8'd83, 8'd85, 8'd86, 8'd84,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd72, 8'd74, 8'd0,  8'd73, 8'd87, 8'd89, 8'd90, 8'd88,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
    };

    // ALU ops with rs1, rs2-or-imm and rd, indexed by op3
    localparam logic [7:0] ALU_CODE [64] = '{
        8'd106, 8'd91,  8'd95,  8'd99,  8'd112, 8'd93,  8'd97,  8'd101,
        8'd108, 8'd0,   8'd119, 8'd120, 8'd114, 8'd0,   8'd123, 8'd124,
        8'd107, 8'd92,  8'd96,  8'd100, 8'd113, 8'd94,  8'd98,  8'd102,
        8'd109, 8'd0,   8'd121, 8'd122, 8'd115, 8'd0,   8'd125, 8'd126,
        8'd110, 8'd116, 8'd111, 8'd117, 8'd118, 8'd103, 8'd104, 8'd105,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd129, 8'd0,   8'd0,   8'd0,   8'd127, 8'd128, 8'd0,   8'd0
    };

    typedef struct packed {
        logic        recognized;
        logic [7:0]  mnemonic;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic        use_imm;
        logic [31:0] immediate;
        logic [31:0] target;
        logic        annul;
        logic [3:0]  special_reg;
        logic [1:0]  reg_class;
    } decode_result_t;

    function automatic logic [7:0] fpop1_code(input logic [8:0] opf);
        logic [7:0] code;
        case (opf)
            9'h041:  code = 8'd132;
            9'h042:  code = 8'd133;
            9'h045:  code = 8'd134;
            9'h046:  code = 8'd135;
            9'h049:  code = 8'd136;
            9'h04A:  code = 8'd137;
            9'h04D:  code = 8'd138;
            9'h04E:  code = 8'd139;
            9'h001:  code = 8'd140;
            9'h005:  code = 8'd141;
            9'h009:  code = 8'd142;
            9'h0D1:  code = 8'd143;
            9'h0D2:  code = 8'd144;
            9'h0C9:  code = 8'd145;
            9'h0C6:  code = 8'd146;
            9'h0C4:  code = 8'd147;
            9'h0C8:  code = 8'd148;
            9'h029:  code = 8'd149;
            9'h02A:  code = 8'd150;
            default: code = K_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] fpop2_code(input logic [8:0] opf);
        logic [7:0] code;
        case (opf)
            9'h051:  code = 8'd151;
            9'h052:  code = 8'd152;
            9'h055:  code = 8'd153;
            9'h056:  code = 8'd154;
            default: code = K_NONE;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/sv8d_if.sv
// Request and result channels of the SPARC v8 decoder.
// Valid/ready handshake; no dependencies.
interface sv8d_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;
    logic [31:0] pc;

    modport source (output valid, output instruction_word, output pc, input ready);
    modport sink   (input valid, input instruction_word, input pc, output ready);
endinterface

interface sv8d_res_if;
    logic        valid;
    logic        ready;
    logic        recognized;
    logic [7:0]  mnemonic;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic        use_imm;
    logic [31:0] immediate;
    logic [31:0] target;
    logic        annul;
    logic [3:0]  special_reg;
    logic [1:0]  reg_class;

    modport source (
        output valid, output recognized, output mnemonic, output dest_reg,
        output src1_reg, output src2_reg, output use_imm, output immediate,
        output target, output annul, output special_reg, output reg_class,
        input ready
    );
    modport sink (
        input valid, input recognized, input mnemonic, input dest_reg,
        input src1_reg, input src2_reg, input use_imm, input immediate,
        input target, input annul, input special_reg, input reg_class,
        output ready
    );
endinterface

>>> rtl/sv8d_decode.sv
// Combinational decode of one SPARC v8 word into a decode_result_t.
// Uses the tables and constants of sv8d_pkg.
module sv8d_decode
    import sv8d_pkg::*;
(
    input  logic [31:0]    instruction_word,
    input  logic [31:0]    pc,
    output decode_result_t result
);

    logic [1:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic        ibit;
    logic [2:0]  op2;
    logic [3:0]  cond;
    logic [5:0]  op3;
    logic [8:0]  opf;
    logic [31:0] simm13;

    assign op     = instruction_word[31:30];
    assign rd     = instruction_word[29:25];
    assign rs1    = instruction_word[18:14];
    assign rs2    = instruction_word[4:0];
    assign ibit   = instruction_word[13];
    assign op2    = instruction_word[24:22];
    assign cond   = instruction_word[28:25];
    assign op3    = instruction_word[24:19];
    assign opf    = instruction_word[13:5];
    assign simm13 = {{19{instruction_word[12]}}, instruction_word[12:0]};

    always_comb
    begin
        logic [7:0]  code;
        logic [4:0]  dst;
        logic [4:0]  s1;
        logic [4:0]  s2;
        logic        ui;
        logic [31:0] imm;
        logic [31:0] tgt;
        logic        ann;
        logic [3:0]  spec;
        logic [1:0]  cls;
        logic        f_rd;
        logic        f_rs1;
        logic        f_rs2;
        logic        f_ri;

        code  = K_NONE;
        dst   = '0;
        s1    = '0;
        s2    = '0;
        ui    = 1'b0;
        imm   = '0;
        tgt   = '0;
        ann   = 1'b0;
        spec  = SR_NONE;
        cls   = CLS_INT;
        f_rd  = 1'b0;
        f_rs1 = 1'b0;
        f_rs2 = 1'b0;
        f_ri  = 1'b0;

        case (op)
            OP_CALL:
            begin
                code = K_CALL;
                tgt  = pc + {instruction_word[29:0], 2'b00};
            end
            OP_FMT2:
            begin
                case (op2)
                    OP2_SETHI:
                    begin
                        if (rd == 5'd0 && instruction_word[21:0] == 22'd0)
                        begin
                            code = K_NOP;
                        end
                        else
                        begin
                            code = K_SETHI;
                            dst  = rd;
                            imm  = {instruction_word[21:0], 10'd0};
                        end
                    end
                    OP2_UNIMP:
                    begin
                        code = K_UNIMP;
                        imm  = {10'd0, instruction_word[21:0]};
                    end
                    OP2_BICC, OP2_FBFCC, OP2_CBCCC:
                    begin
                        if (op2 == OP2_BICC)
                            code = K_BICC + BICC_POS[cond];
                        else if (op2 == OP2_FBFCC)
                            code = K_FBFCC + FCC_POS[cond];
                        else
                            code = K_CBCCC + FCC_POS[cond];
                        ann = instruction_word[29];
                        // sign-extend disp22 from bit 21, then scale by 4
                        tgt = pc + {{8{instruction_word[21]}}, instruction_word[21:0], 2'b00};
                    end
                    default:
                    begin
                        code = K_NONE;
                    end
                endcase
            end
            OP_MEM:
            begin
                code = MEM_CODE[op3];
                if (code != K_NONE)
                begin
                    f_rd  = 1'b1;
                    f_rs1 = 1'b1;
                    f_ri  = 1'b1;
                    if (op3[5:4] == 2'b11)
                        cls = CLS_CP;
                    else if (op3[5:4] == 2'b10)
                        cls = CLS_FP;
                    if (code == K_LDFSR || code == K_STFSR)
                        spec = SR_FSR;
                    else if (code == K_STDFQ)
                        spec = SR_FQ;
                    else if (code == K_LDCSR || code == K_STCSR)
                        spec = SR_CSR;
                    else if (code == K_STDCQ)
                        spec = SR_CQ;
                end
            end
            default:
            begin
                code = ALU_CODE[op3];
                if (code != K_NONE)
                begin
                    f_rd  = 1'b1;
                    f_rs1 = 1'b1;
                    f_ri  = 1'b1;
                end
                else if (op3 inside {[OP3_RDY:OP3_RDTBR]})
                begin
                    code  = K_RD;
                    f_rd  = 1'b1;
                    f_rs1 = 1'b1;
                    // rd %y when rs1 is zero, else an ancillary register
                    if (op3 == OP3_RDY)
                        spec = (rs1 == 5'd0) ? SR_Y : SR_ASR;
                    else
                        spec = {2'b00, op3[1:0]} + SR_ASR;
                end
                else if (op3 inside {[OP3_WRY:OP3_WRTBR]})
                begin
                    code  = K_WR;
                    f_rd  = 1'b1;
                    f_rs1 = 1'b1;
                    f_ri  = 1'b1;
                    if (op3 == OP3_WRY)
                        spec = (rd == 5'd0) ? SR_Y : SR_ASR;
                    else
                        spec = {2'b00, op3[1:0]} + SR_ASR;
                end
                else if (op3 == OP3_FPOP1)
                begin
                    code = fpop1_code(opf);
                    if (code != K_NONE)
                    begin
                        cls   = CLS_FP;
                        f_rd  = 1'b1;
                        f_rs2 = 1'b1;
                        // two-operand arithmetic ops also read rs1
                        if (code <= K_FDIVD)
                            f_rs1 = 1'b1;
                    end
                end
                else if (op3 == OP3_FPOP2)
                begin
                    code = fpop2_code(opf);
                    if (code != K_NONE)
                    begin
                        cls   = CLS_FP;
                        f_rs1 = 1'b1;
                        f_rs2 = 1'b1;
                    end
                end
                else if (op3 == OP3_RETT || op3 == OP3_FLUSH)
                begin
                    code  = (op3 == OP3_RETT) ? K_RETT : K_FLUSH;
                    f_rs1 = 1'b1;
                    f_ri  = 1'b1;
                end
            end
        endcase

        if (f_rd)
            dst = rd;
        if (f_rs1)
            s1 = rs1;
        if (f_rs2)
            s2 = rs2;
        if (f_ri)
        begin
            ui = ibit;
            if (ibit)
                imm = simm13;
            else
                s2 = rs2;
        end

        // drop every field of an unrecognized word
        if (code == K_NONE)
        begin
            dst  = '0;
            s1   = '0;
            s2   = '0;
            ui   = 1'b0;
            imm  = '0;
            tgt  = '0;
            ann  = 1'b0;
            spec = SR_NONE;
            cls  = CLS_INT;
        end

        result.recognized  = (code != K_NONE);
        result.mnemonic    = code;
        result.dest_reg    = dst;
        result.src1_reg    = s1;
        result.src2_reg    = s2;
        result.use_imm     = ui;
        result.immediate   = imm;
        result.target      = tgt;
        result.annul       = ann;
        result.special_reg = spec;
        result.reg_class   = cls;
    end

endmodule

>>> rtl/sparc_v8_instruction_decoder_core.sv
// SPARC v8 instruction decoder core: input register, decode, result register.
// A request accepted into the input register is decoded combinationally and
// moves into the result register once that stage is empty or being drained.
// Throughput: one request per cycle while results drain; both register stages
// advance together and the input stage refills in the cycle the result stage is taken.
// Reset: asynchronous, active low; clears both stage valid flags only.
`include "sparc_v8_instruction_decoder_core_macros.svh"

module sparc_v8_instruction_decoder_core
    import sv8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sv8d_req_if.sink          instr,
    sv8d_res_if.source        decoded
);

    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [31:0]    s1_word_reg;
    logic [31:0]    s1_pc_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    decode_result_t out_res_reg;
    decode_result_t dec_res;
    logic           out_take;
    logic           s1_adv;
    logic           instr_fire;

    // result stage can load when empty or being drained
    assign out_take   = !out_valid_reg || decoded.ready;
    assign s1_adv     = s1_valid_reg && out_take;
    assign instr.ready = !s1_valid_reg || out_take;
    assign instr_fire = instr.valid && instr.ready;

    assign s1_valid_next  = instr_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_take ? s1_valid_reg : out_valid_reg;

    sv8d_decode u_decode (
        .instruction_word (s1_word_reg),
        .pc               (s1_pc_reg),
        .result           (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr_fire)
        begin
            s1_word_reg <= instr.instruction_word;
            s1_pc_reg   <= instr.pc;
        end
        if (s1_adv)
            out_res_reg <= dec_res;
    end

    assign decoded.valid       = out_valid_reg;
    assign decoded.recognized  = out_res_reg.recognized;
    assign decoded.mnemonic    = out_res_reg.mnemonic;
    assign decoded.dest_reg    = out_res_reg.dest_reg;
    assign decoded.src1_reg    = out_res_reg.src1_reg;
    assign decoded.src2_reg    = out_res_reg.src2_reg;
    assign decoded.use_imm     = out_res_reg.use_imm;
    assign decoded.immediate   = out_res_reg.immediate;
    assign decoded.target      = out_res_reg.target;
    assign decoded.annul       = out_res_reg.annul;
    assign decoded.special_reg = out_res_reg.special_reg;
    assign decoded.reg_class   = out_res_reg.reg_class;

    `SV8D_ASSERT_NEXT(a_stage_advance, s1_valid_reg && out_take, out_valid_reg)
    `SV8D_ASSERT_NOW(a_recog_code, out_valid_reg,
        out_res_reg.recognized == (out_res_reg.mnemonic != K_NONE))
    `SV8D_ASSERT_NOW(a_unrecog_zero, out_valid_reg && !out_res_reg.recognized,
        out_res_reg.immediate == 32'd0 && out_res_reg.target == 32'd0
        && out_res_reg.special_reg == SR_NONE)
    `SV8D_ASSERT_NOW(a_imm_no_rs2, out_valid_reg && out_res_reg.use_imm,
        out_res_reg.src2_reg == 5'd0)

endmodule
